>>> hw/rtl/open_addressed_atom_table_defines.svh
// Assertion macros shared by the atom table RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef OPEN_ADDRESSED_ATOM_TABLE_DEFINES_SVH
`define OPEN_ADDRESSED_ATOM_TABLE_DEFINES_SVH

// Condition holds on every clock edge out of reset.
`define OAT_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("atom table: invariant violated");

// Same-cycle implication.
`define OAT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("atom table: implication violated");

// Next-cycle implication.
`define OAT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("atom table: next-cycle implication violated");

`endif

>>> hw/rtl/oat_pkg.sv
// Shared constants for the open-addressed atom table.
// No dependencies.
package oat_pkg;

    localparam int TABLE_SLOTS_DEF = 1024;

    // Fixed field widths of the command and result beats.
    localparam int CMD_W    = 2;
    localparam int TYPE_W   = 5;
    localparam int KEY_W    = 32;
    localparam int HASH_W   = 32;
    localparam int STATUS_W = 3;
    localparam int OUT_W    = 10;

    // Command codes; code 1 (probe) and unused code 3 both act as lookup only.
    localparam logic [CMD_W-1:0] CMD_INTERN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd4;

endpackage

>>> hw/rtl/open_addressed_atom_table.sv
// Open-addressed atom table: interning store of unique (type, key) entries.
// Depends on oat_pkg and open_addressed_atom_table_defines.svh.
//
// A command beat (cmd, type_code, key, hash_value) is taken at a rising edge
// where start is high and busy is low. done is high for exactly one cycle
// with status, slot and entry_total; the receiver cannot stall, so results
// must be taken in that cycle. Home slot is the low log2(TABLE_SLOTS) bits
// of hash_value (TABLE_SLOTS a power of two); probes walk downward and wrap
// from slot 0 to the top.
//
// One slot of the probe chain is checked per cycle: the registered read of
// the next slot is issued while the current one is compared. An intern or
// probe whose chain visits L slots (stop slot included) keeps busy high
// while those slots are checked; done rises in the cycle after the last
// check, when a new beat may already be taken. A remove goes on to scan M
// slots for backward-shift moves, up to and including the empty slot that
// ends the cluster, and then frees the final gap. At a load of at most one
// half, L averages about 1.5 on a hit and 2.5 on a miss.
// After reset a clearing pass writes each of the TABLE_SLOTS slots (1024 by
// default) empty, one per cycle, with busy high; the entry count is 0.
`include "open_addressed_atom_table_defines.svh"

module open_addressed_atom_table #(
    parameter int TABLE_SLOTS = oat_pkg::TABLE_SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [oat_pkg::CMD_W-1:0]     cmd,
    input  logic [oat_pkg::TYPE_W-1:0]    type_code,
    input  logic [oat_pkg::KEY_W-1:0]     key,
    input  logic [oat_pkg::HASH_W-1:0]    hash_value,
    output logic                          done,
    output logic [oat_pkg::STATUS_W-1:0]  status,
    output logic [oat_pkg::OUT_W-1:0]     slot,
    output logic [oat_pkg::OUT_W-1:0]     entry_total
);
    import oat_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W  = SLOT_W;              // holds TABLE_SLOTS/2
    localparam int HALF   = TABLE_SLOTS / 2;
    localparam logic [SLOT_W-1:0] TOP = SLOT_W'(TABLE_SLOTS - 1);

    // Sequencer states.
    localparam logic [2:0] S_CLR   = 3'd0;   // clearing pass after reset
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;   // probe chain walk
    localparam logic [2:0] S_RM    = 3'd3;   // backward-shift scan
    localparam logic [2:0] S_RMEND = 3'd4;   // free the final gap

    typedef struct packed {
        logic              used;
        logic [TYPE_W-1:0] tcode;
        logic [KEY_W-1:0]  kval;
        logic [SLOT_W-1:0] home;
    } entry_t;

    // Slot memory: one write, one registered read per cycle.
    entry_t mem [TABLE_SLOTS];
    entry_t rdata_reg;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    entry_t            wr_data;
    logic [SLOT_W-1:0] rd_addr;

    logic [2:0]          state_reg, state_next;
    logic [SLOT_W-1:0]   step_reg, step_next;   // clear address / walk length
    logic [SLOT_W-1:0]   pos_reg, pos_next;     // slot whose data is in rdata_reg
    logic [SLOT_W-1:0]   gap_reg, gap_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;

    // Captured command beat.
    logic [CMD_W-1:0]  cmd_reg;
    logic [TYPE_W-1:0] type_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [SLOT_W-1:0] home_reg;

    logic              accept;
    logic [SLOT_W-1:0] pos_dn;
    logic              match;
    logic              move;
    logic              last_step;
    logic              ins_beat;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign pos_dn = (pos_reg == '0) ? TOP : pos_reg - 1'b1;
    assign match  = rdata_reg.used && (rdata_reg.tcode == type_reg)
                    && (rdata_reg.kval == key_reg);
    assign last_step = (step_reg == TOP);
    assign ins_beat  = done_reg && (status_reg == ST_INSERTED);

    // A scanned entry may fill the gap when its home is not cyclically
    // between the gap and its current slot.
    always_comb
    begin
        if (pos_reg < gap_reg)
            move = (rdata_reg.home >= gap_reg) || (rdata_reg.home < pos_reg);
        else if (pos_reg > gap_reg)
            move = (rdata_reg.home >= gap_reg) && (rdata_reg.home < pos_reg);
        else
            move = 1'b0;
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        pos_next    = pos_reg;
        gap_next    = gap_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        slot_next   = slot_reg;
        wr_en       = 1'b0;
        wr_addr     = gap_reg;
        wr_data     = '0;
        rd_addr     = pos_dn;

        unique case (state_reg)
            S_CLR:
            begin
                wr_en     = 1'b1;
                wr_addr   = step_reg;
                step_next = step_reg + 1'b1;
                if (last_step)
                begin
                    state_next = S_IDLE;
                    step_next  = '0;
                end
            end

            S_IDLE:
            begin
                rd_addr = hash_value[SLOT_W-1:0];
                if (start)
                begin
                    pos_next   = hash_value[SLOT_W-1:0];
                    step_next  = '0;
                    state_next = S_CHK;
                end
            end

            S_CHK:
            begin
                if (!rdata_reg.used || match || last_step)
                begin
                    if (match)
                    begin
                        if (cmd_reg == CMD_REMOVE)
                        begin
                            gap_next   = pos_reg;
                            slot_next  = pos_reg;
                            pos_next   = pos_dn;
                            step_next  = '0;
                            state_next = S_RM;
                        end
                        else
                        begin
                            status_next = ST_FOUND;
                            slot_next   = pos_reg;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                    else
                    begin
                        // Miss: the walk stopped at pos_reg.
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                        slot_next  = pos_reg;
                        if (cmd_reg == CMD_INTERN)
                        begin
                            if ((count_reg >= CNT_W'(HALF)) || rdata_reg.used)
                            begin
                                status_next = ST_FULL;
                                slot_next   = '0;
                            end
                            else
                            begin
                                wr_en        = 1'b1;
                                wr_addr      = pos_reg;
                                wr_data      = '{used: 1'b1, tcode: type_reg,
                                                 kval: key_reg, home: home_reg};
                                count_next   = count_reg + 1'b1;
                                status_next  = ST_INSERTED;
                            end
                        end
                        else
                        begin
                            status_next = ST_ABSENT;
                        end
                    end
                end
                else
                begin
                    pos_next  = pos_dn;
                    step_next = step_reg + 1'b1;
                end
            end

            S_RM:
            begin
                if (!rdata_reg.used)
                begin
                    state_next = S_RMEND;
                end
                else
                begin
                    if (move)
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = gap_reg;
                        wr_data  = rdata_reg;
                        gap_next = pos_reg;
                    end
                    if (last_step)
                    begin
                        state_next = S_RMEND;
                    end
                    else
                    begin
                        pos_next  = pos_dn;
                        step_next = step_reg + 1'b1;
                    end
                end
            end

            S_RMEND:
            begin
                wr_en       = 1'b1;
                wr_addr     = gap_reg;
                status_next = ST_REMOVED;
                if (count_reg != '0)
                    count_next = count_reg - 1'b1;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Slot memory.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            step_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers, no reset.
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        gap_reg    <= gap_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        if (accept)
        begin
            cmd_reg  <= cmd;
            type_reg <= type_code;
            key_reg  <= key;
            home_reg <= hash_value[SLOT_W-1:0];
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign slot        = OUT_W'(slot_reg);
    assign entry_total = OUT_W'(count_reg);

    `OAT_ASSERT_HOLDS(a_count_bound, count_reg <= CNT_W'(HALF))
    `OAT_ASSERT_IMP(a_insert_counts, ins_beat, count_reg == $past(count_reg) + 1'b1)
    `OAT_ASSERT_NXT(a_accept_busy, accept, busy)
    `OAT_ASSERT_IMP(a_done_idle, done_reg, state_reg == S_IDLE)
    `OAT_ASSERT_IMP(a_idle_no_write, state_reg == S_IDLE, !wr_en)

endmodule
